// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/irqcq_pkg.sv =====
`default_nettype none

package irqcq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int SOURCE_COUNT_DEF = 6;

  localparam int SRC_W   = 3;
  localparam int EN_W    = 6;
  localparam int DATUM_W = 32;
  localparam int KIND_W  = 16;
  localparam int TICK_W  = 32;
  localparam int SEQ_W   = 16;
  localparam int CNT_W   = 32;
  localparam int PEND_W  = 5;

  localparam int ENTRY_W      = TICK_W + DATUM_W + KIND_W + SEQ_W;
  localparam int META_FIXED_W = 2 * CNT_W + SEQ_W;

  localparam int IN_DATA_W   = DATUM_W + KIND_W + TICK_W;
  localparam int IN_USER_W   = 1 + SRC_W;
  localparam int OUT_RAW_W   = ENTRY_W + PEND_W + 2 * CNT_W;
  localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_USER_W  = 3;

  typedef enum logic {
    CMD_EVENT = 1'b0,
    CMD_TAKE  = 1'b1
  } cmd_t;

  typedef enum logic [OUT_USER_W-1:0] {
    STATUS_OK         = 3'd0,
    STATUS_EMPTY      = 3'd1,
    STATUS_DROPPED    = 3'd2,
    STATUS_BAD_SOURCE = 3'd3,
    STATUS_DISABLED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_META = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic meta_we;
    logic ent_we;
    logic ent_re;
  } step_ctl_t;

  typedef struct packed {
    status_t           status;
    logic              take_ok;
    logic [PEND_W-1:0] pending;
    logic [CNT_W-1:0]  seen;
    logic [CNT_W-1:0]  lost;
  } step_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/irqcq_ram.sv =====
`default_nettype none

module irqcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [AW-1:0]          raddr,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/irqcq_update.sv =====
`default_nettype none

module irqcq_update import irqcq_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int SOURCE_COUNT = SOURCE_COUNT_DEF
) (
  input  wire logic                                  cmd,
  input  wire logic [SRC_W-1:0]                      src,
  input  wire logic [EN_W-1:0]                       enabled,
  input  wire logic [DATUM_W-1:0]                    datum,
  input  wire logic [KIND_W-1:0]                     kind,
  input  wire logic [TICK_W-1:0]                     tick,
  input  wire logic [2*$clog2(2*QUEUE_DEPTH)+META_FIXED_W-1:0] meta_cur,
  output logic      [2*$clog2(2*QUEUE_DEPTH)+META_FIXED_W-1:0] meta_next,
  output logic      [$clog2(SOURCE_COUNT*QUEUE_DEPTH)-1:0]     ent_addr,
  output logic      [ENTRY_W-1:0]                    ent_wdata,
  output step_ctl_t                                  ctl,
  output step_res_t                                  res
);

  localparam int PW  = $clog2(2 * QUEUE_DEPTH);
  localparam int EAW = $clog2(SOURCE_COUNT * QUEUE_DEPTH);
  localparam logic [PW:0]    SPAN    = (PW+1)'(2 * QUEUE_DEPTH);
  localparam logic [PW-1:0]  SPAN_M1 = PW'(2 * QUEUE_DEPTH - 1);
  localparam logic [PW-1:0]  QD_P    = PW'(QUEUE_DEPTH);
  localparam logic [EAW-1:0] QD_E    = EAW'(QUEUE_DEPTH);

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [CNT_W-1:0] lost;
    logic [CNT_W-1:0] seen;
    logic [PW-1:0]    rp;
    logic [PW-1:0]    wp;
  } meta_t;

  meta_t cur;
  meta_t nxt;
  logic [PW:0]            diff;
  logic [PW:0]            occ_wide;
  logic [PW-1:0]          occ;
  logic [PW-1:0]          occ_after;
  logic [PW-1:0]          wp_slot;
  logic [PW-1:0]          rp_slot;
  logic [2**SRC_W-1:0]    en_ext;
  logic                   src_ok;
  logic                   en;
  logic                   full;
  logic                   empty;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == SPAN_M1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_slot(input logic [PW-1:0] p);
    return (p >= QD_P) ? p - QD_P : p;
  endfunction

  assign cur       = meta_t'(meta_cur);
  assign meta_next = nxt;

  assign diff     = {1'b0, cur.wp} - {1'b0, cur.rp};
  assign occ_wide = diff[PW] ? diff + SPAN : diff;
  assign occ      = occ_wide[PW-1:0];
  assign full     = (occ == QD_P);
  assign empty    = (occ == '0);
  assign wp_slot  = ptr_slot(cur.wp);
  assign rp_slot  = ptr_slot(cur.rp);

  assign src_ok = ({1'b0, src} < (SRC_W+1)'(SOURCE_COUNT));
  assign en_ext = (2**SRC_W)'(enabled);
  assign en     = en_ext[src];

  assign ent_wdata = {cur.seq, kind, datum, tick};

  always_comb begin
    nxt       = cur;
    ctl       = '0;
    res       = '0;
    occ_after = occ;
    ent_addr  = EAW'(src) * QD_E + EAW'(wp_slot);
    if (!src_ok) begin
      res.status = STATUS_BAD_SOURCE;
    end else begin
      res.status  = STATUS_OK;
      ctl.meta_we = 1'b1;
      if (cmd == CMD_EVENT) begin
        if (!en) begin
          res.status  = STATUS_DISABLED;
          ctl.meta_we = 1'b0;
        end else begin
          nxt.seen = cur.seen + 1'b1;
          nxt.seq  = cur.seq + 1'b1;
          if (full) begin
            nxt.lost   = cur.lost + 1'b1;
            res.status = STATUS_DROPPED;
          end else begin
            ctl.ent_we = 1'b1;
            nxt.wp     = ptr_inc(cur.wp);
            occ_after  = occ + 1'b1;
          end
        end
      end else begin
        if (empty) begin
          res.status = STATUS_EMPTY;
        end else begin
          ctl.ent_re  = 1'b1;
          res.take_ok = 1'b1;
          ent_addr    = EAW'(src) * QD_E + EAW'(rp_slot);
          nxt.rp      = ptr_inc(cur.rp);
          occ_after   = occ - 1'b1;
        end
      end
      res.pending = PEND_W'(occ_after);
      res.seen    = nxt.seen;
      res.lost    = nxt.lost;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/irq_event_capture_queues.sv =====
// Per-source interrupt event capture. Each source owns a ring of QUEUE_DEPTH
// entries in a shared entry memory, and its pointers, seen and lost counts and
// next sequence number sit in a small per-source record memory. When an item
// is accepted the source's record is read; in the META state it is updated and
// written back while the entry memory is written (event) or read (take); in the
// DONE state the result beat is loaded into the output register and the next
// item is accepted in that same cycle while the output is taken; a stalled
// output holds the block in DONE. A new item is not accepted before the record
// of the last one is written back. Records carry a valid bit per source, so no
// clearing pass follows reset; entries that were never written are never
// returned. Events from sources whose enabled bit is clear are reported as
// disabled and ignored, while takes work on any valid source.
`default_nettype none

module irq_event_capture_queues import irqcq_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int SOURCE_COUNT = SOURCE_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [EN_W-1:0]       cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // event_datum, event_kind, timestamp
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // command, source
  input  wire logic [IN_USER_W-1:0]  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // out_tick, out_datum, out_kind, out_seq, pending_count, events_seen,
  // events_lost, zero padding
  output logic      [OUT_DATA_W-1:0] m_tdata,
  // status
  output logic      [OUT_USER_W-1:0] m_tuser
);

  localparam int PW  = $clog2(2 * QUEUE_DEPTH);
  localparam int MW  = 2 * PW + META_FIXED_W;
  localparam int SW  = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
  localparam int EAW = $clog2(SOURCE_COUNT * QUEUE_DEPTH);

  state_t              state;
  logic [EN_W-1:0]     enabled;
  logic                cmd_q;
  logic [SRC_W-1:0]    src_q;
  logic [DATUM_W-1:0]  datum_q;
  logic [KIND_W-1:0]   kind_q;
  logic [TICK_W-1:0]   tick_q;
  logic                in_acc;
  logic                out_free;
  logic                load;
  logic                src_in_ok;
  logic [SRC_W-1:0]    src_in;
  logic [SOURCE_COUNT-1:0] meta_valid;
  logic [2**SW-1:0]    valid_ext;
  logic                meta_hit;
  logic [MW-1:0]       meta_rdata;
  logic [MW-1:0]       meta_cur;
  logic [MW-1:0]       meta_next;
  logic                meta_we;
  logic [EAW-1:0]      ent_addr;
  logic [ENTRY_W-1:0]  ent_wdata;
  logic [ENTRY_W-1:0]  ent_rdata;
  logic [ENTRY_W-1:0]  ent_out;
  step_ctl_t           ctl;
  step_res_t           res;
  step_res_t           res_q;

  assign src_in    = s_tuser[SRC_W:1];
  assign src_in_ok = ({1'b0, src_in} < (SRC_W+1)'(SOURCE_COUNT));
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) || ((state == ST_DONE) && out_free);
  assign in_acc    = s_tvalid && s_tready;
  assign load      = (state == ST_DONE) && out_free;
  assign valid_ext = (2**SW)'(meta_valid);
  assign meta_cur  = meta_hit ? meta_rdata : '0;
  assign meta_we   = (state == ST_META) && ctl.meta_we;
  assign ent_out   = res_q.take_ok ? ent_rdata : '0;

  irqcq_ram #(
    .WIDTH (MW),
    .DEPTH (SOURCE_COUNT)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (src_q[SW-1:0]),
    .wdata (meta_next),
    .re    (in_acc && src_in_ok),
    .raddr (src_in[SW-1:0]),
    .rdata (meta_rdata)
  );

  irqcq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SOURCE_COUNT * QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    ((state == ST_META) && ctl.ent_we),
    .waddr (ent_addr),
    .wdata (ent_wdata),
    .re    ((state == ST_META) && ctl.ent_re),
    .raddr (ent_addr),
    .rdata (ent_rdata)
  );

  irqcq_update #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .SOURCE_COUNT (SOURCE_COUNT)
  ) u_update (
    .cmd       (cmd_q),
    .src       (src_q),
    .enabled   (enabled),
    .datum     (datum_q),
    .kind      (kind_q),
    .tick      (tick_q),
    .meta_cur  (meta_cur),
    .meta_next (meta_next),
    .ent_addr  (ent_addr),
    .ent_wdata (ent_wdata),
    .ctl       (ctl),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      enabled    <= '0;
      meta_valid <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        enabled <= cfg_wdata;
      end
      if (meta_we) begin
        meta_valid[src_q[SW-1:0]] <= 1'b1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_META;
          end
        end
        ST_META: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (in_acc) begin
            state <= ST_META;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q    <= s_tuser[0];
      src_q    <= src_in;
      datum_q  <= s_tdata[DATUM_W-1:0];
      kind_q   <= s_tdata[DATUM_W+KIND_W-1:DATUM_W];
      tick_q   <= s_tdata[IN_DATA_W-1:DATUM_W+KIND_W];
      meta_hit <= src_in_ok && valid_ext[src_in[SW-1:0]];
    end
    if (state == ST_META) begin
      res_q <= res;
    end
    if (load) begin
      m_tuser <= res_q.status;
      m_tdata <= {(OUT_DATA_W-OUT_RAW_W)'(0), res_q.lost, res_q.seen, res_q.pending, ent_out};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/irqcq_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module irqcq_checker import irqcq_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [OUT_USER_W-1:0] m_tuser
);

  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")
  `ASSERT_CLK(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready, "input taken in the cycle after an accept")
  `ASSERT_CLK(a_bad_source_zero, clk, rst, m_tvalid && (m_tuser == STATUS_BAD_SOURCE) |-> (m_tdata == '0), "bad source beat carries data")
  `ASSERT_CLK(a_empty_zero, clk, rst, m_tvalid && (m_tuser == STATUS_EMPTY) |-> (m_tdata[ENTRY_W+PEND_W-1:0] == '0), "empty take beat carries an entry or a count")
  `ASSERT_CLK_ALWAYS(a_reset_clears, clk, rst |=> !m_tvalid, "result valid straight after reset")

endmodule

bind irq_event_capture_queues irqcq_checker u_irqcq_checker (.*);

`default_nettype wire
